### rtl/stt_pkg.sv
package stt_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int TICK_UNIT_DEF = 100;

    localparam int MODE_W    = 2;
    localparam int DUR_W     = 16;
    localparam int SLOT_W    = 4;
    localparam int KIND_W    = 3;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_REG   = 2'd1,
        MODE_UNREG = 2'd2
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_REGISTERED   = 3'd0,
        KIND_TOO_SHORT    = 3'd1,
        KIND_TABLE_FULL   = 3'd2,
        KIND_REMOVED      = 3'd3,
        KIND_NOT_FOUND    = 3'd4,
        KIND_FIRED_RELOAD = 3'd5,
        KIND_FIRED_FREED  = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_REG,
        S_UNREG,
        S_SWEEP,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic             reloads;
        logic [DUR_W-1:0] reload_value;
        logic [DUR_W-1:0] remaining;
    } row_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic reg_commit;
        logic unreg_commit;
        logic sweep_start;
        logic sweep_run;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic sweep_done;
        logic pend_vld;
    } status_t;

endpackage

### rtl/software_timer_table.sv
// register: duration divided by TICK_UNIT by reciprocal multiply in S_DIV, committed in S_REG
// unregister: the latched beat is committed in S_UNREG
// tick: one slot per cycle via the timer row memory (one read, one write) unless a fire stalls
// a fire result waits for the next fire or the flush to set tlast; results stall on m_tready
// a new beat is taken as soon as the previous one is done, while its result may still wait
// synchronous active-low reset clears all slots to free; timer rows need no clearing pass
module software_timer_table #(
    parameter int SLOTS     = stt_pkg::SLOTS_DEF,
    parameter int TICK_UNIT = stt_pkg::TICK_UNIT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [stt_pkg::S_TDATA_W-1:0]  s_tdata,   // duration[15:0], periodic, slot_id[3:0]
    input  logic [stt_pkg::MODE_W-1:0]     s_tuser,   // mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [stt_pkg::M_TDATA_W-1:0]  m_tdata,   // slot[3:0]
    output logic [stt_pkg::KIND_W-1:0]     m_tuser,   // kind
    output logic                           m_tlast
);
    import stt_pkg::*;

    cmd_t    cmd;
    status_t status;

    stt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .cmd      (cmd),
        .status   (status)
    );

    stt_dp #(
        .SLOTS     (SLOTS),
        .TICK_UNIT (TICK_UNIT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/stt_ctrl.sv
module stt_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [stt_pkg::MODE_W-1:0]  mode,
    output stt_pkg::cmd_t               cmd,
    input  stt_pkg::status_t            status
);
    import stt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    case (mode_t'(mode))
                        MODE_TICK: begin
                            cmd.sweep_start = 1'b1;
                            state_next      = S_SWEEP;
                        end
                        MODE_REG:   state_next = S_DIV;
                        MODE_UNREG: state_next = S_UNREG;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = S_REG;
                end
            end
            S_REG: begin
                if (status.out_free) begin
                    cmd.reg_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_UNREG: begin
                if (status.out_free) begin
                    cmd.unreg_commit = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_SWEEP: begin
                cmd.sweep_run = 1'b1;
                if (status.sweep_done) begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!status.pend_vld) begin
                    state_next = S_IDLE;
                end else if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // a tick must have flushed its held result before the next beat is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !status.pend_vld)
        else $error("held fire result left behind at idle");

endmodule

### rtl/stt_dp.sv
module stt_dp #(
    parameter int SLOTS     = stt_pkg::SLOTS_DEF,
    parameter int TICK_UNIT = stt_pkg::TICK_UNIT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [stt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  stt_pkg::cmd_t                  cmd,
    output stt_pkg::status_t               status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [stt_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [stt_pkg::KIND_W-1:0]     m_tuser,
    output logic                           m_tlast
);
    import stt_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int QS      = DUR_W + $clog2(TICK_UNIT);
    localparam int RECIP_W = DUR_W + 1;
    localparam int PROD_W  = DUR_W + RECIP_W;
    localparam longint RECIP = ((longint'(1) << QS) + longint'(TICK_UNIT) - 1)
                               / longint'(TICK_UNIT);

    function automatic logic [SLOT_W-1:0] to_slot(input logic [SW-1:0] idx);
        logic [SW+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

    // latched beat
    logic [DUR_W-1:0]     q_reg;
    logic                 periodic_reg;
    logic [SLOT_W-1:0]    slot_id_reg;
    logic                 short_reg;

    // timer state
    logic [SLOTS-1:0]     active_reg;
    logic [SLOTS-1:0]     active_next;
    row_t                 mem [SLOTS];
    logic [SW-1:0]        free_reg;
    logic [SW-1:0]        free_next;
    logic                 full_reg;

    // sweep pipeline
    logic [CW-1:0]        rd_idx_reg;
    logic                 s_vld_reg;
    logic [SW-1:0]        s_idx_reg;
    row_t                 rd_row_reg;
    logic                 pend_vld_reg;
    kind_t                pend_kind_reg;
    logic [SLOT_W-1:0]    pend_slot_reg;

    // output register
    logic                 m_tvalid_reg;
    kind_t                out_kind_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic                 out_last_reg;

    logic [PROD_W-1:0]    prod;
    logic [SLOTS-1:0]     hit;
    logic                 found;
    logic                 stage_act;
    logic [DUR_W-1:0]     rem_dec;
    logic                 fire;
    logic                 stall;
    logic                 adv;
    logic                 out_free;
    logic                 mem_we;
    logic [SW-1:0]        mem_waddr;
    row_t                 mem_wdata;
    logic                 emit;
    kind_t                e_kind;
    logic [SLOT_W-1:0]    e_slot;
    logic                 e_last;

    assign out_free = !m_tvalid_reg || m_tready;

    // quotient by reciprocal multiplication, exact over the whole duration range
    assign prod = PROD_W'(q_reg) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            q_reg        <= s_tdata[DUR_W-1:0];
            periodic_reg <= s_tdata[DUR_W];
            slot_id_reg  <= s_tdata[DUR_W+SLOT_W:DUR_W+1];
            short_reg    <= s_tdata[DUR_W-1:0] < DUR_W'(TICK_UNIT);
        end else if (cmd.div_step) begin
            q_reg <= DUR_W'(prod >> QS);
        end
    end

    // lowest free slot
    always_comb begin
        free_next = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_next = SW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        free_reg <= free_next;
        full_reg <= &active_reg;
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            hit[i] = (int'(slot_id_reg) == i);
        end
    end
    assign found = |(hit & active_reg);

    // sweep stage
    assign stage_act = s_vld_reg && active_reg[s_idx_reg];
    assign rem_dec   = rd_row_reg.remaining - 1'b1;
    assign fire      = stage_act && (rem_dec == '0);
    assign stall     = fire && pend_vld_reg && !out_free;
    assign adv       = cmd.sweep_run && !stall;

    always_comb begin
        active_next = active_reg;
        mem_we      = 1'b0;
        mem_waddr   = s_idx_reg;
        mem_wdata   = rd_row_reg;
        if (cmd.reg_commit && !short_reg && !full_reg) begin
            active_next[free_reg]  = 1'b1;
            mem_we                 = 1'b1;
            mem_waddr              = free_reg;
            mem_wdata.reloads      = periodic_reg;
            mem_wdata.reload_value = q_reg;
            mem_wdata.remaining    = q_reg;
        end else if (cmd.unreg_commit) begin
            active_next = active_reg & ~hit;
        end else if (adv && stage_act) begin
            mem_we              = 1'b1;
            mem_wdata.remaining = (fire && rd_row_reg.reloads) ?
                                  rd_row_reg.reload_value : rem_dec;
            if (fire && !rd_row_reg.reloads) begin
                active_next[s_idx_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && rd_idx_reg < CW'(SLOTS)) begin
            rd_row_reg <= mem[rd_idx_reg[SW-1:0]];
            s_idx_reg  <= rd_idx_reg[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            s_vld_reg  <= 1'b0;
        end else if (cmd.sweep_start) begin
            rd_idx_reg <= '0;
            s_vld_reg  <= 1'b0;
        end else if (adv) begin
            if (rd_idx_reg < CW'(SLOTS)) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                s_vld_reg  <= 1'b1;
            end else begin
                s_vld_reg <= 1'b0;
            end
        end
    end

    // one fire result is held back until the next shows whether it is the final one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
        end else if (cmd.sweep_start || cmd.flush) begin
            pend_vld_reg <= 1'b0;
        end else if (adv && fire) begin
            pend_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && fire) begin
            pend_kind_reg <= rd_row_reg.reloads ? KIND_FIRED_RELOAD : KIND_FIRED_FREED;
            pend_slot_reg <= to_slot(s_idx_reg);
        end
    end

    always_comb begin
        emit   = 1'b0;
        e_kind = KIND_REGISTERED;
        e_slot = '0;
        e_last = 1'b1;
        if (cmd.reg_commit) begin
            emit = 1'b1;
            if (short_reg) begin
                e_kind = KIND_TOO_SHORT;
            end else if (full_reg) begin
                e_kind = KIND_TABLE_FULL;
            end else begin
                e_slot = to_slot(free_reg);
            end
        end else if (cmd.unreg_commit) begin
            emit   = 1'b1;
            e_kind = found ? KIND_REMOVED : KIND_NOT_FOUND;
            e_slot = slot_id_reg;
        end else if (adv && fire && pend_vld_reg) begin
            emit   = 1'b1;
            e_kind = pend_kind_reg;
            e_slot = pend_slot_reg;
            e_last = 1'b0;
        end else if (cmd.flush) begin
            emit   = 1'b1;
            e_kind = pend_kind_reg;
            e_slot = pend_slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_kind_reg <= e_kind;
            out_slot_reg <= e_slot;
            out_last_reg <= e_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {{(M_TDATA_W-SLOT_W){1'b0}}, out_slot_reg};
    assign m_tlast  = out_last_reg;

    assign status.div_done   = 1'b1;
    assign status.out_free   = out_free;
    assign status.sweep_done = (rd_idx_reg == CW'(SLOTS)) && !s_vld_reg;
    assign status.pend_vld   = pend_vld_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !emit)
        else $error("result beat overwritten while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.reg_commit && !short_reg && !full_reg) |-> !active_reg[free_reg])
        else $error("timer loaded into a busy slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && stage_act && !(fire && !rd_row_reg.reloads))
        |=> (mem[$past(s_idx_reg)].remaining != '0))
        else $error("active timer left with zero count");

endmodule

### sim/software_timer_table_tb.sv
module software_timer_table_tb;
    import stt_pkg::*;

    localparam int SLOT_N = SLOTS_DEF;
    localparam int TICK = TICK_UNIT_DEF;
    localparam int RANDOM_ITEMS = 380;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 300;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } result_t;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [DUR_W-1:0]  dur;
        logic              per;
        logic [SLOT_W-1:0] sid;
        bit                typed;
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [MODE_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;

    // typed expectation travelling alongside the beat
    bit                tag_typed = 1'b0;
    kind_t             tag_kind = KIND_REGISTERED;
    logic [SLOT_W-1:0] tag_slot = '0;

    bit stall_request = 1'b0;
    bit calm = 1'b0;
    int quiet_cycles = 0;
    int mismatch_count = 0;

    // timer table mirror
    bit               tmr_active [SLOT_N];
    logic [DUR_W-1:0] tmr_left   [SLOT_N];
    logic [DUR_W-1:0] tmr_reload [SLOT_N];
    bit               tmr_periodic [SLOT_N];

    result_t caused [SLOT_N];
    int      caused_n;
    result_t due_results [$];

    stim_row_t dir_rows [25];

    software_timer_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic note_result(input kind_t k, input int s);
        caused[caused_n] = '{k, s[SLOT_W-1:0], 1'b0};
        caused_n++;
    endtask

    task automatic advance_timer_table(input logic [MODE_W-1:0] mode,
                                       input logic [DUR_W-1:0] dur, input logic per,
                                       input logic [SLOT_W-1:0] sid);
        int free_slot;
        caused_n = 0;
        case (mode)
            MODE_REG: begin
                if (dur < TICK) begin
                    note_result(KIND_TOO_SHORT, 0);
                end else begin
                    free_slot = -1;
                    for (int i = SLOT_N - 1; i >= 0; i--)
                        if (!tmr_active[i]) free_slot = i;
                    if (free_slot < 0) begin
                        note_result(KIND_TABLE_FULL, 0);
                    end else begin
                        tmr_active[free_slot] = 1'b1;
                        tmr_left[free_slot] = DUR_W'(dur / TICK);
                        tmr_reload[free_slot] = DUR_W'(dur / TICK);
                        tmr_periodic[free_slot] = per;
                        note_result(KIND_REGISTERED, free_slot);
                    end
                end
            end
            MODE_UNREG: begin
                if (sid < SLOT_N && tmr_active[sid]) begin
                    tmr_active[sid] = 1'b0;
                    note_result(KIND_REMOVED, int'(sid));
                end else begin
                    note_result(KIND_NOT_FOUND, int'(sid));
                end
            end
            MODE_TICK: begin
                for (int i = 0; i < SLOT_N; i++) begin
                    if (tmr_active[i]) begin
                        tmr_left[i] = tmr_left[i] - 1'b1;
                        if (tmr_left[i] == '0) begin
                            if (tmr_periodic[i]) begin
                                tmr_left[i] = tmr_reload[i];
                                note_result(KIND_FIRED_RELOAD, i);
                            end else begin
                                tmr_active[i] = 1'b0;
                                note_result(KIND_FIRED_FREED, i);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        if (caused_n > 0) caused[caused_n - 1].last = 1'b1;
    endtask

    always @(posedge aclk) begin : monitor
        result_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat kind %0d tdata %0h last %0b",
                                              m_tuser, m_tdata, m_tlast));
                end else begin
                    want = due_results.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
                    if (m_tdata !== {{(M_TDATA_W-SLOT_W){1'b0}}, want.slot})
                        report_mismatch($sformatf("tdata %0h, want slot %0d", m_tdata, want.slot));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("tlast %0b, want %0b", m_tlast, want.last));
                end
            end
            if (s_tvalid && s_tready) begin
                advance_timer_table(s_tuser, s_tdata[DUR_W-1:0], s_tdata[DUR_W],
                                    s_tdata[DUR_W+SLOT_W:DUR_W+1]);
                if (tag_typed) begin
                    if (caused_n != 1 || caused[0].kind != tag_kind || caused[0].slot != tag_slot)
                        report_mismatch("mirror disagrees with typed row");
                    due_results.push_back('{tag_kind, tag_slot, 1'b1});
                end else begin
                    for (int i = 0; i < caused_n; i++) due_results.push_back(caused[i]);
                end
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("software_timer_table_tb failed");
        $finish;
    end

    initial begin : sink
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_request && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 22);
            end
        end
    end

    task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [DUR_W-1:0] dur,
                             input logic per, input logic [SLOT_W-1:0] sid,
                             input bit typed, input kind_t kind, input logic [SLOT_W-1:0] slot);
        while (!calm && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W-DUR_W-1-SLOT_W){1'b0}}, sid, per, dur};
        s_tuser <= mode;
        tag_typed <= typed;
        tag_kind <= kind;
        tag_slot <= slot;
        do @(posedge aclk); while (!s_tready);
    endtask

    initial begin : source
        int sent;
        int pick;
        logic [MODE_W-1:0] mode;
        logic [DUR_W-1:0] dur;
        stim_row_t r;

        for (int i = 0; i < SLOT_N; i++) begin
            tmr_active[i] = 1'b0;
            tmr_left[i] = '0;
            tmr_reload[i] = '0;
            tmr_periodic[i] = 1'b0;
        end

        dir_rows[0]  = '{MODE_UNREG, 16'd0, 1'b0, 4'd15, 1'b1, KIND_NOT_FOUND, 4'd15};
        dir_rows[1]  = '{MODE_TICK, 16'd0, 1'b0, 4'd0, 1'b0, KIND_REGISTERED, 4'd0};
        dir_rows[2]  = '{MODE_REG, 16'd0, 1'b0, 4'd0, 1'b1, KIND_TOO_SHORT, 4'd0};
        dir_rows[3]  = '{MODE_REG, 16'd99, 1'b1, 4'd15, 1'b1, KIND_TOO_SHORT, 4'd0};
        dir_rows[4]  = '{MODE_SPARE, 16'hffff, 1'b1, 4'd15, 1'b0, KIND_REGISTERED, 4'd0};
        dir_rows[5]  = '{MODE_REG, 16'd100, 1'b1, 4'd0, 1'b1, KIND_REGISTERED, 4'd0};
        dir_rows[6]  = '{MODE_REG, 16'hffff, 1'b0, 4'd15, 1'b1, KIND_REGISTERED, 4'd1};
        dir_rows[7]  = '{MODE_REG, 16'd200, 1'b0, 4'd0, 1'b1, KIND_REGISTERED, 4'd2};
        // fill slots 3 to 15, all due on the second tick
        for (int i = 8; i <= 20; i++)
            dir_rows[i] = '{MODE_REG, 16'(200 + 7 * (i - 8)), 1'(i), 4'd0,
                            1'b1, KIND_REGISTERED, 4'(i - 5)};
        dir_rows[21] = '{MODE_REG, 16'd1000, 1'b1, 4'd7, 1'b1, KIND_TABLE_FULL, 4'd0};
        dir_rows[22] = '{MODE_TICK, 16'hffff, 1'b1, 4'd15, 1'b0, KIND_REGISTERED, 4'd0};
        dir_rows[23] = '{MODE_TICK, 16'd0, 1'b0, 4'd0, 1'b0, KIND_REGISTERED, 4'd0};
        dir_rows[24] = '{MODE_UNREG, 16'd0, 1'b1, 4'd1, 1'b1, KIND_REMOVED, 4'd1};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            send_beat(r.mode, r.dur, r.per, r.sid, r.typed, r.kind, r.slot);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == 150) stall_request <= 1'b1;
            calm <= (sent >= 250 && sent < 330);
            pick = $urandom_range(99);
            if (pick < 5) mode = MODE_SPARE;
            else if (pick < 40) mode = MODE_REG;
            else if (pick < 62) mode = MODE_UNREG;
            else mode = MODE_TICK;
            case ($urandom_range(9))
                0: dur = DUR_W'($urandom_range(TICK - 1));
                1: dur = DUR_W'($urandom);
                default: dur = DUR_W'($urandom_range(TICK, 6 * TICK - 1));
            endcase
            send_beat(mode, dur, 1'($urandom), SLOT_W'($urandom), 1'b0, KIND_REGISTERED, '0);
            if (mode != MODE_SPARE) sent++;
        end
        s_tvalid <= 1'b0;
        calm <= 1'b0;

        while (due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("software_timer_table_tb passed");
        end else begin
            $display("software_timer_table_tb failed");
        end
        $finish;
    end

endmodule
